[hw/rtl/dec_pkg.sv]
// Shared types, codes and helpers for the data EEPROM controller.
// No dependencies; used by every module of the block.
package dec_pkg;

  localparam int ARRAY_DEPTH = 256;
  localparam int IDX_W       = $clog2(ARRAY_DEPTH);
  localparam int DUR_W       = 16;
  localparam int DUR_RESET   = 4000;

  localparam logic [7:0] UNLOCK_FIRST  = 8'h55;
  localparam logic [7:0] UNLOCK_SECOND = 8'hAA;
  localparam logic [7:0] ERASED_BYTE   = 8'hFF;

  // control register bit positions
  localparam int CTRL_RD   = 0;
  localparam int CTRL_WR   = 1;
  localparam int CTRL_WREN = 2;
  localparam int CTRL_ERR  = 3;
  localparam int CTRL_DONE = 4;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEL_ADDR   = 2'd0,
    SEL_DATA   = 2'd1,
    SEL_CTRL   = 2'd2,
    SEL_UNLOCK = 2'd3
  } sel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] sel;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       write_finished;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_t;

  // Address modulo ARRAY_DEPTH by compare-subtract; quotient fits in four bits
  // because the depth is at least 16.
  function automatic logic [IDX_W-1:0] array_index(input logic [7:0] a);
    logic [11:0] r;
    logic [11:0] lim;
    r = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      lim = 12'(ARRAY_DEPTH) << k;
      if (r >= lim) begin
        r = r - lim;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/dec_mem.sv]
// Byte array with per-entry valid bits; unwritten entries read as erased.
// One write port, one read port with registered data. Uses dec_pkg.
module dec_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  dec_pkg::store_t           store,
  input  logic [dec_pkg::IDX_W-1:0] rd_idx,
  output logic [7:0]                rd_data
);

  logic [7:0]                  mem [dec_pkg::ARRAY_DEPTH];
  logic [dec_pkg::ARRAY_DEPTH-1:0] valid;
  logic [7:0]                  rd_q;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (store.en) begin
      mem[store.idx] <= store.data;
    end
    // write-first bypass keeps the read port coherent with a same-cycle store
    if (store.en && store.idx == rd_idx) begin
      rd_q <= store.data;
    end else begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (store.en) begin
        valid[store.idx] <= 1'b1;
      end
      rd_vld <= valid[rd_idx] || (store.en && store.idx == rd_idx);
    end
  end

  assign rd_data = rd_vld ? rd_q : dec_pkg::ERASED_BYTE;

endmodule

[hw/rtl/dec_regs.sv]
// Register file, unlock sequencer and write timer; one item per accepted word.
// Uses dec_pkg; reads the array through dec_mem's registered port.
module dec_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dec_pkg::DUR_W-1:0] cfg_wdata,
  input  logic                      item_vld,
  input  dec_pkg::item_t            item,
  input  logic [7:0]                arr_byte,
  output logic [dec_pkg::IDX_W-1:0] rd_idx,
  output dec_pkg::store_t           store,
  output dec_pkg::result_t          result
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FIRST = 2'd1,
    ST_ARMED = 2'd2
  } unlock_t;

  logic [dec_pkg::DUR_W-1:0] duration;
  logic [7:0]                address_reg, address_reg_next;
  logic [7:0]                data_reg, data_reg_next;
  logic                      wr_enable, wr_enable_next;
  logic                      busy, busy_next;
  logic                      error_flag, error_flag_next;
  logic                      done_flag, done_flag_next;
  unlock_t                   stage, stage_next;
  logic [dec_pkg::DUR_W-1:0] busy_count, busy_count_next;
  logic [dec_pkg::DUR_W-1:0] count_dec;
  logic [7:0]                pend_addr, pend_addr_next;
  logic [7:0]                pend_data, pend_data_next;
  logic [7:0]                v;

  assign v = item.value;

  always_comb begin
    address_reg_next = address_reg;
    data_reg_next    = data_reg;
    wr_enable_next   = wr_enable;
    busy_next        = busy;
    error_flag_next  = error_flag;
    done_flag_next   = done_flag;
    stage_next       = stage;
    busy_count_next  = busy_count;
    pend_addr_next   = pend_addr;
    pend_data_next   = pend_data;
    store            = '0;
    result           = '0;
    count_dec        = (busy_count != '0) ? busy_count - 1'b1 : busy_count;

    if (item_vld) begin
      unique case (item.kind)
        dec_pkg::KIND_READ: begin
          unique case (item.sel)
            dec_pkg::SEL_ADDR:   result.read_value = address_reg;
            dec_pkg::SEL_DATA:   result.read_value = data_reg;
            dec_pkg::SEL_CTRL:   result.read_value = {3'd0, done_flag, error_flag,
                                                      wr_enable, busy, 1'b0};
            dec_pkg::SEL_UNLOCK: result.read_value = '0;
            default:             result.read_value = '0;
          endcase
        end
        dec_pkg::KIND_WRITE: begin
          stage_next = ST_IDLE;
          unique case (item.sel)
            dec_pkg::SEL_ADDR: address_reg_next = v;
            dec_pkg::SEL_DATA: data_reg_next = v;
            dec_pkg::SEL_CTRL: begin
              if (v[dec_pkg::CTRL_RD]) begin
                data_reg_next = arr_byte;
              end
              wr_enable_next  = v[dec_pkg::CTRL_WREN];
              error_flag_next = v[dec_pkg::CTRL_ERR];
              done_flag_next  = v[dec_pkg::CTRL_DONE];
              if (v[dec_pkg::CTRL_WR] && !busy && v[dec_pkg::CTRL_WREN] &&
                  stage == ST_ARMED) begin
                busy_next       = 1'b1;
                busy_count_next = (duration != '0) ? duration : 16'd1;
                pend_addr_next  = address_reg;
                pend_data_next  = data_reg_next;
              end
            end
            dec_pkg::SEL_UNLOCK: begin
              if (v == dec_pkg::UNLOCK_FIRST) begin
                stage_next = ST_FIRST;
              end else if (v == dec_pkg::UNLOCK_SECOND && stage == ST_FIRST) begin
                stage_next = ST_ARMED;
              end
            end
            default: stage_next = ST_IDLE;
          endcase
        end
        dec_pkg::KIND_TICK: begin
          if (busy) begin
            busy_count_next = count_dec;
            if (count_dec == '0) begin
              store.en              = 1'b1;
              store.idx             = dec_pkg::array_index(pend_addr);
              store.data            = pend_data;
              busy_next             = 1'b0;
              done_flag_next        = 1'b1;
              result.write_finished = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // keep the array read port pointed at the address that follows this item
  assign rd_idx = dec_pkg::array_index(address_reg_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration    <= 16'(dec_pkg::DUR_RESET);
      address_reg <= '0;
      data_reg    <= '0;
      wr_enable   <= 1'b0;
      busy        <= 1'b0;
      error_flag  <= 1'b0;
      done_flag   <= 1'b0;
      stage       <= ST_IDLE;
      busy_count  <= '0;
      pend_addr   <= '0;
      pend_data   <= '0;
    end else begin
      if (cfg_we) begin
        duration <= cfg_wdata;
      end
      address_reg <= address_reg_next;
      data_reg    <= data_reg_next;
      wr_enable   <= wr_enable_next;
      busy        <= busy_next;
      error_flag  <= error_flag_next;
      done_flag   <= done_flag_next;
      stage       <= stage_next;
      busy_count  <= busy_count_next;
      pend_addr   <= pend_addr_next;
      pend_data   <= pend_data_next;
    end
  end

endmodule

[hw/rtl/data_eeprom_controller_core.sv]
// Top level of the data EEPROM controller: stream ports and result register.
// Depends on dec_pkg, dec_regs and dec_mem.
//
//  port group | dir | tdata            | tuser
//  s_*        | in  | write_value[7:0] | kind[1:0], register_select[3:2]
//  m_*        | out | read_value[7:0]  | write_finished[0]
//  cfg_*      | in  | write_duration_ticks[15:0], plain write strobe
//
// One word per clock: a word accepted at one edge has its result in m_* the
// next cycle. The path per word is the register update and one array access;
// array reads come from a registered port that always tracks the address
// register, so a read-bit set finds its byte without waiting.
// s_tready drops only while a result sits unclaimed in the output register.
// Reset (rst, synchronous) clears control state and the array's valid bits at
// once; the whole array then reads as erased (0xFF), no clearing pass needed.
module data_eeprom_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // write_duration_ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] write_value
  input  logic [3:0]  s_tuser,     // [1:0] kind, [3:2] register_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // [7:0] read_value
  output logic        m_tuser      // [0] write_finished
);

  dec_pkg::item_t                item;
  dec_pkg::result_t              result;
  dec_pkg::store_t               store;
  logic [dec_pkg::IDX_W-1:0]     rd_idx;
  logic [7:0]                    arr_byte;
  logic                          accept;

  // output slot is free, or being emptied this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign item.kind  = s_tuser[1:0];
  assign item.sel   = s_tuser[3:2];
  assign item.value = s_tdata;

  dec_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item_vld (accept),
    .item     (item),
    .arr_byte (arr_byte),
    .rd_idx   (rd_idx),
    .store    (store),
    .result   (result)
  );

  dec_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .store  (store),
    .rd_idx (rd_idx),
    .rd_data(arr_byte)
  );

  // result register: payload held while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result.read_value;
      m_tuser <= result.write_finished;
    end
  end

endmodule

[hw/rtl/dec_chk.sv]
// Port-level checker for the data EEPROM controller, bound to the top level.
// Uses dec_pkg for the kind codes.
module dec_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [3:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] != dec_pkg::KIND_READ
    |=> m_tvalid && m_tdata == 8'd0)
    else $error("read_value nonzero for a word that is not a read");

  a_finish_tick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] != dec_pkg::KIND_TICK
    |=> m_tvalid && !m_tuser)
    else $error("write_finished raised on a word that is not a tick");

endmodule

bind data_eeprom_controller_core dec_chk u_dec_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

[test/dec_reply_checker.sv]
`timescale 1ns / 1ps
// Reply checker for the data EEPROM controller: follows both stream channels
// and the config strobe, predicts each reply and compares it. Needs dec_pkg.
module dec_reply_checker
  import dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [1:0] STAGE_IDLE  = 2'd0;
  localparam logic [1:0] STAGE_FIRST = 2'd1;
  localparam logic [1:0] STAGE_ARMED = 2'd2;

  logic [DUR_W-1:0] dur_cfg;
  logic [7:0]       addr_q;
  logic [7:0]       data_q;
  logic             wren_q;
  logic             busy_q;
  logic             err_q;
  logic             done_q;
  logic [1:0]       unlock_q;
  logic [DUR_W-1:0] busy_left;
  logic [7:0]       latched_addr;
  logic [7:0]       latched_data;
  logic [7:0]       array_copy [ARRAY_DEPTH];

  result_t pending_replies[$];
  int      errors = 0;

  // advances the shadow state by one word and returns the reply it causes
  function automatic result_t eeprom_access(input item_t w);
    result_t r;
    r = '0;
    case (w.kind)
      KIND_READ: begin
        case (w.sel)
          SEL_ADDR: r.read_value = addr_q;
          SEL_DATA: r.read_value = data_q;
          SEL_CTRL: begin
            r.read_value[CTRL_WR]   = busy_q;
            r.read_value[CTRL_WREN] = wren_q;
            r.read_value[CTRL_ERR]  = err_q;
            r.read_value[CTRL_DONE] = done_q;
          end
          default: ;
        endcase
      end
      KIND_WRITE: begin
        if (w.sel == SEL_UNLOCK) begin
          if (w.value == UNLOCK_FIRST) begin
            unlock_q = STAGE_FIRST;
          end else if (w.value == UNLOCK_SECOND && unlock_q == STAGE_FIRST) begin
            unlock_q = STAGE_ARMED;
          end else begin
            unlock_q = STAGE_IDLE;
          end
        end else begin
          case (w.sel)
            SEL_ADDR: addr_q = w.value;
            SEL_DATA: data_q = w.value;
            default: begin
              if (w.value[CTRL_RD]) begin
                data_q = array_copy[addr_q % ARRAY_DEPTH];
              end
              wren_q = w.value[CTRL_WREN];
              err_q  = w.value[CTRL_ERR];
              done_q = w.value[CTRL_DONE];
              // start test sees write enable as just written
              if (w.value[CTRL_WR] && !busy_q && wren_q && unlock_q == STAGE_ARMED) begin
                busy_q       = 1'b1;
                busy_left    = (dur_cfg == 0) ? DUR_W'(1) : dur_cfg;
                latched_addr = addr_q;
                latched_data = data_q;
              end
            end
          endcase
          unlock_q = STAGE_IDLE;
        end
      end
      KIND_TICK: begin
        if (busy_q) begin
          if (busy_left != 0) begin
            busy_left = busy_left - 1'b1;
          end
          if (busy_left == 0) begin
            array_copy[latched_addr % ARRAY_DEPTH] = latched_data;
            busy_q           = 1'b0;
            done_q           = 1'b1;
            r.write_finished = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   word;
    result_t want;
    if (rst) begin
      dur_cfg      = DUR_W'(DUR_RESET);
      addr_q       = '0;
      data_q       = '0;
      wren_q       = 1'b0;
      busy_q       = 1'b0;
      err_q        = 1'b0;
      done_q       = 1'b0;
      unlock_q     = STAGE_IDLE;
      busy_left    = '0;
      latched_addr = '0;
      latched_data = '0;
      for (int i = 0; i < ARRAY_DEPTH; i++) begin
        array_copy[i] = ERASED_BYTE;
      end
      pending_replies.delete();
    end else begin
      if (cfg_we) begin
        dur_cfg = cfg_wdata;
      end
      // reply first: it can only belong to a word taken at an earlier edge
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with none due, actual read_value %h write_finished %b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tdata !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, m_tdata);
            errors++;
          end
          if (m_tuser !== want.write_finished) begin
            $display("%0t: write_finished expected %b actual %b",
                     $time, want.write_finished, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        word.kind  = s_tuser[1:0];
        word.sel   = s_tuser[3:2];
        word.value = s_tdata;
        pending_replies.push_back(eeprom_access(word));
      end
    end
    fail_count  <= errors;
    outstanding <= pending_replies.size();
  end

endmodule

[test/tb_data_eeprom_controller_core.sv]
`timescale 1ns / 1ps
// Testbench top for data_eeprom_controller_core: clock, reset, word stimulus,
// config writes and verdict. Needs dec_pkg, the core and dec_reply_checker.
module tb_data_eeprom_controller_core;
  import dec_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int WATCHDOG_CYCLES  = 500_000;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 20;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // control bit masks
  localparam logic [7:0] RD_BIT   = 8'h01 << CTRL_RD;
  localparam logic [7:0] WR_BIT   = 8'h01 << CTRL_WR;
  localparam logic [7:0] WREN_BIT = 8'h01 << CTRL_WREN;
  localparam logic [7:0] ERR_BIT  = 8'h01 << CTRL_ERR;
  localparam logic [7:0] DONE_BIT = 8'h01 << CTRL_DONE;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;      // [7:0] write_value
  logic [3:0]  s_tuser;      // [1:0] kind, [3:2] register_select
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;      // [7:0] read_value
  logic        m_tuser;      // [0] write_finished

  int fail_count;
  int outstanding;

  // idle rates in percent, changed per phase by the stimulus
  int send_idle_pct  = 25;
  int recv_stall_pct = 63;
  // long receiver hold-off, requested by stimulus, counted by the sink process
  int stall_reqs = 0;
  int stall_seen = 0;
  int hold_left  = 0;

  int          words_sent = 0;
  logic [15:0] cur_duration = 16'(DUR_RESET);

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  data_eeprom_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  dec_reply_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Reply sink: random stalls, or a long hold-off while a request is pending.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      hold_left  = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(WATCHDOG_CYCLES * 2 * CLK_HALF);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one word, with a random idle gap in front, and returns at the edge
  // where it is taken. valid stays up between back-to-back words.
  task automatic send_word(input logic [1:0] k, input logic [1:0] s, input logic [7:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= {s, k};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic reg_write(input sel_t s, input logic [7:0] v);
    send_word(KIND_WRITE, s, v);
  endtask

  task automatic reg_read(input sel_t s);
    send_word(KIND_READ, s, 8'($urandom_range(255)));
  endtask

  task automatic tick();
    send_word(KIND_TICK, sel_t'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // Sender goes quiet until every reply due has been taken. The first edge
  // is skipped since the reply count is registered and lags the accept.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  // Busy length is only changed with the block idle.
  task automatic set_duration(input logic [15:0] d);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_duration = d;
  endtask

  function automatic int busy_ticks();
    return (cur_duration == 0) ? 1 : int'(cur_duration);
  endfunction

  // Mostly the few lowest and highest addresses, so read-backs hit stored bytes.
  function automatic logic [7:0] pick_address();
    if ($urandom_range(9) < 6) begin
      return $urandom_range(1) ? 8'($urandom_range(3)) : 8'(252 + $urandom_range(3));
    end
    return 8'($urandom_range(255));
  endfunction

  // Ticks with sparse status reads, for the long busy stretches.
  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2047) == 0) begin
        reg_read(SEL_CTRL);
      end
      tick();
    end
  endtask

  // One byte program: address, data, unlock pair, start, ticks, read-back.
  // Four times in ten the unlock or the enable is spoiled.
  task automatic program_sequence();
    logic [7:0] ctrl;
    int flaw;
    int n;
    flaw = $urandom_range(9);
    reg_write(SEL_ADDR, pick_address());
    reg_write(SEL_DATA, 8'($urandom_range(255)));
    if ($urandom_range(3) == 0) begin
      reg_read(SEL_CTRL);
    end
    case (flaw)
      0: begin
        // pair in the wrong order
        reg_write(SEL_UNLOCK, UNLOCK_SECOND);
        reg_write(SEL_UNLOCK, UNLOCK_FIRST);
      end
      1: begin
        // another register write between the two halves
        reg_write(SEL_UNLOCK, UNLOCK_FIRST);
        reg_write(SEL_DATA, 8'($urandom_range(255)));
        reg_write(SEL_UNLOCK, UNLOCK_SECOND);
      end
      2: begin
        reg_write(SEL_UNLOCK, UNLOCK_FIRST);
        reg_write(SEL_UNLOCK, 8'($urandom_range(255)));
      end
      default: begin
        reg_write(SEL_UNLOCK, UNLOCK_FIRST);
        if ($urandom_range(7) == 0) begin
          reg_read(sel_t'($urandom_range(3)));   // reads keep the stage
        end
        reg_write(SEL_UNLOCK, UNLOCK_SECOND);
      end
    endcase
    ctrl = 8'($urandom_range(255)) | WR_BIT;
    if (flaw != 3) begin
      ctrl = ctrl | WREN_BIT;
    end
    reg_write(SEL_CTRL, ctrl);
    n = busy_ticks() + $urandom_range(2);
    while (n > 0) begin
      if ($urandom_range(4) == 0) begin
        reg_read(sel_t'($urandom_range(3)));
      end else if ($urandom_range(9) == 0) begin
        // writes while busy must not disturb the latched byte
        reg_write(sel_t'($urandom_range(2)), 8'($urandom_range(255)));
      end else begin
        tick();
        n--;
      end
    end
    reg_write(SEL_CTRL, RD_BIT | (8'($urandom_range(255)) & ~WR_BIT));
    reg_read(SEL_DATA);
  endtask

  task automatic random_burst(input int count);
    int stop_at;
    int pick;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        program_sequence();
      end else if (pick < 60) begin
        reg_write(SEL_ADDR, pick_address());
        reg_write(SEL_CTRL, RD_BIT | 8'($urandom_range(255)));
        reg_read(SEL_DATA);
      end else if (pick < 75) begin
        reg_read(sel_t'($urandom_range(3)));
      end else if (pick < 85) begin
        tick();
      end else begin
        // noise, unused kind included
        send_word(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, with a short busy length ----
    set_duration(16'd6);
    reg_read(SEL_ADDR);
    reg_read(SEL_DATA);
    reg_read(SEL_CTRL);
    reg_read(SEL_UNLOCK);                          // unlock reads as zero
    send_word(KIND_UNUSED, SEL_CTRL, 8'hFF);       // unused kind does nothing
    reg_write(SEL_ADDR, 8'hFF);
    reg_write(SEL_CTRL, RD_BIT);                   // erased byte into data
    reg_read(SEL_DATA);
    reg_write(SEL_DATA, 8'h00);
    reg_write(SEL_UNLOCK, UNLOCK_FIRST);
    reg_write(SEL_UNLOCK, UNLOCK_SECOND);
    reg_write(SEL_CTRL, WR_BIT | ERR_BIT | DONE_BIT);  // no enable: no start
    reg_read(SEL_CTRL);
    reg_write(SEL_UNLOCK, UNLOCK_FIRST);
    reg_write(SEL_CTRL, WR_BIT | WREN_BIT);        // only half unlocked
    reg_write(SEL_UNLOCK, UNLOCK_FIRST);
    reg_write(SEL_UNLOCK, UNLOCK_SECOND);
    reg_write(SEL_CTRL, WR_BIT | WREN_BIT);        // starts: 0x00 to 0xFF
    reg_read(SEL_CTRL);
    reg_write(SEL_ADDR, 8'h10);
    reg_write(SEL_DATA, 8'h5A);
    reg_write(SEL_UNLOCK, UNLOCK_FIRST);
    reg_write(SEL_UNLOCK, UNLOCK_SECOND);
    reg_write(SEL_CTRL, WR_BIT | WREN_BIT | RD_BIT);  // start while busy ignored
    reg_write(SEL_CTRL, 8'h00);                    // zero never clears busy
    reg_read(SEL_CTRL);

    // finish that write at full speed
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tick_run(busy_ticks());
    reg_read(SEL_CTRL);
    reg_write(SEL_ADDR, 8'hFF);
    reg_write(SEL_CTRL, RD_BIT);
    reg_read(SEL_DATA);

    // ---- random phases: sender idles 25, receiver 63 ----
    send_idle_pct  = 25;
    recv_stall_pct = 63;
    set_duration(16'd1);
    random_burst(250);

    // ---- and the other way round, with the long hold-off and a full pause ----
    send_idle_pct  = 63;
    recv_stall_pct = 25;
    set_duration(16'd3);
    random_burst(120);
    stall_reqs++;
    send_idle_pct = 0;
    random_burst(40);
    send_idle_pct = 63;
    wait_drained();
    random_burst(90);

    // ---- no idling ----
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_duration(16'd0);                           // zero acts as one
    random_burst(100);

    set_duration(16'd40);
    reg_write(SEL_ADDR, 8'h80);
    reg_write(SEL_DATA, 8'($urandom_range(255)));
    reg_write(SEL_UNLOCK, UNLOCK_FIRST);
    reg_write(SEL_UNLOCK, UNLOCK_SECOND);
    reg_write(SEL_CTRL, WR_BIT | WREN_BIT);
    tick_run(busy_ticks());
    reg_write(SEL_CTRL, RD_BIT);
    reg_read(SEL_DATA);

    set_duration(16'd2);
    random_burst(60);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
